// File: design/okle_pkg.sv
// Types and constants shared by the ordered key list engine.
package okle_pkg;

  localparam logic [2:0] REQ_INS_KEY  = 3'd0;
  localparam logic [2:0] REQ_INS_HEAD = 3'd1;
  localparam logic [2:0] REQ_INS_TAIL = 3'd2;
  localparam logic [2:0] REQ_DEL_KEY  = 3'd3;
  localparam logic [2:0] REQ_DEL_HEAD = 3'd4;
  localparam logic [2:0] REQ_DEL_TAIL = 3'd5;
  localparam logic [2:0] REQ_LIST     = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] new_key;
    logic signed [31:0] anchor_key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               item_valid;
    logic signed [31:0] item_key;
    logic               last;
    logic [4:0]         element_count;
  } res_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_LIST,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    AT_KEY,
    AT_HEAD,
    AT_TAIL
  } site_t;

  typedef struct packed {
    op_t                op;
    site_t              site;
    logic signed [31:0] new_key;
    logic signed [31:0] anchor_key;
  } cmd_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic signed [31:0] key;
  } cell_ctl_t;

endpackage

// File: design/okle_front.sv
// Request intake: decodes requests and queues them for the sequencer.
module okle_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  okle_pkg::req_t req,
  output okle_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import okle_pkg::*;

  cmd_t q0, q1;
  logic v0, v1;
  cmd_t incoming;
  logic push;

  function automatic cmd_t classify(req_t r);
    cmd_t c;
    c.new_key    = r.new_key;
    c.anchor_key = r.anchor_key;
    c.op         = OP_NONE;
    c.site       = AT_KEY;
    unique case (r.req_type)
      REQ_INS_KEY:  begin c.op = OP_INS;  c.site = AT_KEY;  end
      REQ_INS_HEAD: begin c.op = OP_INS;  c.site = AT_HEAD; end
      REQ_INS_TAIL: begin c.op = OP_INS;  c.site = AT_TAIL; end
      REQ_DEL_KEY:  begin c.op = OP_DEL;  c.site = AT_KEY;  end
      REQ_DEL_HEAD: begin c.op = OP_DEL;  c.site = AT_HEAD; end
      REQ_DEL_TAIL: begin c.op = OP_DEL;  c.site = AT_TAIL; end
      REQ_LIST:     begin c.op = OP_LIST; c.site = AT_KEY;  end
      default:      begin c.op = OP_NONE; c.site = AT_KEY;  end
    endcase
    return c;
  endfunction

  assign busy      = v1;
  assign push      = start && !v1;
  assign incoming  = classify(req);
  assign cmd       = q0;
  assign cmd_valid = v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      priority if (cmd_pop && v0 && push) begin
        if (v1) begin
          q0 <= q1;
          q1 <= incoming;
        end else begin
          q0 <= incoming;
        end
      end else if (cmd_pop && v0) begin
        q0 <= q1;
        v0 <= v1;
        v1 <= 1'b0;
      end else if (push) begin
        if (!v0) begin
          q0 <= incoming;
          v0 <= 1'b1;
        end else begin
          q1 <= incoming;
          v1 <= 1'b1;
        end
      end else begin
        v0 <= v0;
      end
    end
  end

endmodule

// File: design/okle_cells.sv
// Shifting chain of key cells: insert, delete and rotate in place.
module okle_cells #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  okle_pkg::cell_ctl_t             ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]   pos,
  input  logic [$clog2(CAPACITY+1)-1:0]   count,
  output logic signed [31:0]              head
);
  import okle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [31:0] slot [CAPACITY];

  assign head = slot[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    localparam logic [CNT_W-1:0] NXT = CNT_W'(i + 1);
    logic signed [31:0] upper;
    logic signed [31:0] lower;

    if (i == CAPACITY - 1) begin : g_top
      assign upper = slot[i];
    end else begin : g_mid
      assign upper = slot[i+1];
    end
    if (i == 0) begin : g_bot
      assign lower = ctl.key;
    end else begin : g_rest
      assign lower = slot[i-1];
    end

    always_ff @(posedge clk) begin
      unique case (ctl.mode)
        CM_HOLD: slot[i] <= slot[i];
        CM_INSERT: begin
          if (IDX == pos) slot[i] <= ctl.key;
          else if (IDX > pos) slot[i] <= lower;
        end
        CM_DELETE: begin
          if (IDX >= pos) slot[i] <= upper;
        end
        CM_ROTATE: begin
          if (NXT < count) slot[i] <= upper;
          else if (NXT == count) slot[i] <= slot[0];
        end
        default: slot[i] <= slot[i];
      endcase
    end
  end

endmodule

// File: design/okle_back.sv
// Sequencer: checks requests against the count, scans, updates and lists.
module okle_back #(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  okle_pkg::cmd_t        cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  output logic                  done,
  output okle_pkg::res_t        res
);
  import okle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_LIST
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  op_t                op, op_next;
  logic signed [31:0] mkey, mkey_next;
  logic signed [31:0] ikey, ikey_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               found, found_next;
  logic [CNT_W-1:0]   fpos, fpos_next;
  res_t               res_next;
  logic               done_next;

  cell_ctl_t          ctl;
  logic [CNT_W-1:0]   cell_pos;
  logic signed [31:0] head;

  function automatic res_t mk_res(logic [1:0] st, logic v, logic signed [31:0] k,
                                  logic l, logic [CNT_W-1:0] c);
    res_t r;
    r.status        = st;
    r.item_valid    = v;
    r.item_key      = k;
    r.last          = l;
    r.element_count = 5'(c);
    return r;
  endfunction

  okle_cells #(.CAPACITY(CAPACITY)) u_cells (
    .clk   (clk),
    .ctl   (ctl),
    .pos   (cell_pos),
    .count (count),
    .head  (head)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    op_next    = op;
    mkey_next  = mkey;
    ikey_next  = ikey;
    idx_next   = idx;
    found_next = found;
    fpos_next  = fpos;
    res_next   = res;
    done_next  = 1'b0;
    cmd_pop    = 1'b0;
    ctl.mode   = CM_HOLD;
    ctl.key    = ikey;
    cell_pos   = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          op_next    = cmd.op;
          ikey_next  = cmd.new_key;
          idx_next   = '0;
          found_next = 1'b0;
          fpos_next  = '0;
          ctl.key    = cmd.new_key;
          unique case (cmd.op)
            OP_INS: begin
              if (cmd.site == AT_KEY && count == '0) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_EMPTY, 1'b0, '0, 1'b1, count);
              end else if (count >= CAP_CNT) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_FULL, 1'b0, '0, 1'b1, count);
              end else if (cmd.site == AT_KEY) begin
                mkey_next  = cmd.anchor_key;
                state_next = S_SCAN;
              end else begin
                ctl.mode   = CM_INSERT;
                cell_pos   = (cmd.site == AT_HEAD) ? '0 : count;
                count_next = count + ONE;
                done_next  = 1'b1;
                res_next   = mk_res(ST_OK, 1'b0, '0, 1'b1, count + ONE);
              end
            end
            OP_DEL: begin
              if (count == '0) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_EMPTY, 1'b0, '0, 1'b1, count);
              end else if (cmd.site == AT_KEY) begin
                mkey_next  = cmd.new_key;
                state_next = S_SCAN;
              end else begin
                ctl.mode   = CM_DELETE;
                cell_pos   = (cmd.site == AT_HEAD) ? '0 : count - ONE;
                count_next = count - ONE;
                done_next  = 1'b1;
                res_next   = mk_res(ST_OK, 1'b0, '0, 1'b1, count - ONE);
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                done_next = 1'b1;
                res_next  = mk_res(ST_OK, 1'b0, '0, 1'b1, count);
              end else begin
                state_next = S_LIST;
              end
            end
            OP_NONE: begin
              done_next = 1'b1;
              res_next  = mk_res(ST_OK, 1'b0, '0, 1'b1, count);
            end
            default: begin
              done_next = 1'b1;
              res_next  = mk_res(ST_OK, 1'b0, '0, 1'b1, count);
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.mode = CM_ROTATE;
        if (!found && head == mkey) begin
          found_next = 1'b1;
          fpos_next  = idx;
        end
        idx_next = idx + ONE;
        if (idx == count - ONE) state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (op == OP_INS) begin
          ctl.mode   = CM_INSERT;
          cell_pos   = found ? fpos + ONE : count;
          count_next = count + ONE;
          res_next   = mk_res(ST_OK, 1'b0, '0, 1'b1, count + ONE);
        end else if (found) begin
          ctl.mode   = CM_DELETE;
          cell_pos   = fpos;
          count_next = count - ONE;
          res_next   = mk_res(ST_OK, 1'b0, '0, 1'b1, count - ONE);
        end else begin
          res_next = mk_res(ST_MISSING, 1'b0, '0, 1'b1, count);
        end
      end
      S_LIST: begin
        ctl.mode  = CM_ROTATE;
        done_next = 1'b1;
        res_next  = mk_res(ST_OK, 1'b1, head, idx == count - ONE, count);
        idx_next  = idx + ONE;
        if (idx == count - ONE) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      op    <= OP_NONE;
      idx   <= '0;
      found <= 1'b0;
      fpos  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      op    <= op_next;
      idx   <= idx_next;
      found <= found_next;
      fpos  <= fpos_next;
    end
    mkey <= mkey_next;
    ikey <= ikey_next;
    res  <= res_next;
  end

endmodule

// File: design/ordered_key_list_engine.sv
// Top level of the ordered key list engine.
//
// Holds an ordered list of up to CAPACITY signed 32-bit keys.
// Requests enter on req and transfer at a rising edge with start high and
// busy low. A two-entry queue sits in front of the sequencer, so busy rises
// only when two requests wait behind the one in progress.
// Results leave on res with done high for exactly one cycle each; the
// receiver must take them as they come, there is no back-pressure.
// Work per request in the sequencer:
//   insert/delete at head or tail, refused requests, unused code: done in
//   the idle state as the request is taken; insert or delete by key: one
//   rotation of the cell chain to search, then the update
//   list: one element per cycle from the head of the rotating chain
// With the queue empty, a request done in the idle state is popped from the
// queue and its result registered; a list first moves to the list state.
// Reset empties the list and the queue; key cells are not cleared.
module ordered_key_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  okle_pkg::req_t req,
  output logic           done,
  output okle_pkg::res_t res
);
  import okle_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  okle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  okle_back #(.CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .done      (done),
    .res       (res)
  );

endmodule

// File: design/okle_checker.sv
// Port-level checks on the ordered key list engine, bound to the top level.
module okle_checker #(
  parameter int CAPACITY = 16
) (
  input logic           clk,
  input logic           rst,
  input logic           done,
  input okle_pkg::res_t res
);
  import okle_pkg::*;

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe straight after reset");

  a_listed_ok: assert property (@(posedge clk) disable iff (rst)
    done && res.item_valid |-> res.status == ST_OK)
    else $error("listed element with non-ok status");

  a_idle_key_zero: assert property (@(posedge clk) disable iff (rst)
    done && !res.item_valid |-> res.item_key == '0 && res.last)
    else $error("update result carries a key or is not last");

  a_list_burst: assert property (@(posedge clk) disable iff (rst)
    done && res.item_valid && !res.last |=> done && res.item_valid
      && res.element_count == $past(res.element_count))
    else $error("list burst broken");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> int'(res.element_count) <= CAPACITY)
    else $error("element count above capacity");

endmodule

bind ordered_key_list_engine okle_checker #(.CAPACITY(CAPACITY)) u_okle_checker (.*);

// File: test/tb.sv
// Testbench for the ordered key list engine: directed and random requests checked by a list predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import okle_pkg::*;

  localparam int CAPACITY = 16;
  localparam int TOTAL_ITEMS = 250;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int MAX_PRINTED = 100;
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  localparam logic [2:0] INSERT_KINDS [3] = '{REQ_INS_KEY, REQ_INS_HEAD, REQ_INS_TAIL};
  localparam logic [2:0] DELETE_KINDS [3] = '{REQ_DEL_KEY, REQ_DEL_HEAD, REQ_DEL_TAIL};

  typedef enum int {
    GROW,
    SHRINK,
    CHURN
  } traffic_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t res;

  logic signed [31:0] model_keys [$];
  res_t pending_results [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;

  ordered_key_list_engine #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .res(res)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("tb: %0t %s got %0h want %0h", $realtime, field, got, want);
    end
  endtask

  function automatic int find_key(logic signed [31:0] key);
    foreach (model_keys[i]) begin
      if (model_keys[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic apply_request(req_t r);
    res_t e;
    int pos;
    int n;
    n = model_keys.size();
    e = '0;
    e.status = ST_OK;
    e.last = 1'b1;
    case (r.req_type)
      REQ_INS_KEY: begin
        if (n == 0) begin
          e.status = ST_EMPTY;
        end else if (n >= CAPACITY) begin
          e.status = ST_FULL;
        end else begin
          pos = find_key(r.anchor_key);
          model_keys.insert(pos < 0 ? n : pos + 1, r.new_key);
        end
      end
      REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (n >= CAPACITY) begin
          e.status = ST_FULL;
        end else if (r.req_type == REQ_INS_HEAD) begin
          model_keys.push_front(r.new_key);
        end else begin
          model_keys.push_back(r.new_key);
        end
      end
      REQ_DEL_KEY: begin
        if (n == 0) begin
          e.status = ST_EMPTY;
        end else begin
          pos = find_key(r.new_key);
          if (pos < 0) e.status = ST_MISSING;
          else model_keys.delete(pos);
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL: begin
        if (n == 0) begin
          e.status = ST_EMPTY;
        end else if (r.req_type == REQ_DEL_HEAD) begin
          void'(model_keys.pop_front());
        end else begin
          void'(model_keys.pop_back());
        end
      end
      REQ_LIST: begin
        for (int i = 0; i < n; i++) begin
          e.item_valid = 1'b1;
          e.item_key = model_keys[i];
          e.last = (i == n - 1);
          e.element_count = 5'(n);
          pending_results.push_back(e);
        end
      end
      default: ;
    endcase
    if (!(r.req_type == REQ_LIST && n > 0)) begin
      e.element_count = 5'(model_keys.size());
      pending_results.push_back(e);
    end
  endtask

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic send_req(logic [2:0] kind, logic signed [31:0] key,
                          logic signed [31:0] anchor);
    req_t r;
    int gap;
    r = '{req_type: kind, new_key: key, anchor_key: anchor};
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    apply_request(r);
    items_sent++;
  endtask

  // hold off until every expected result has arrived
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && model_keys.size() > 0) begin
      return model_keys[$urandom_range(0, model_keys.size() - 1)];
    end
    if (roll < 7) return $urandom_range(0, 6) - 3;
    if (roll == 7) return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
    return $urandom();
  endfunction

  task automatic send_random(traffic_t mode);
    int roll;
    int ins_w;
    int del_w;
    ins_w = (mode == GROW) ? 70 : (mode == SHRINK) ? 15 : 40;
    del_w = (mode == GROW) ? 15 : (mode == SHRINK) ? 70 : 40;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) begin
      send_req(INSERT_KINDS[$urandom_range(0, 2)], pick_key(), pick_key());
    end else if (roll < ins_w + del_w) begin
      send_req(DELETE_KINDS[$urandom_range(0, 2)], pick_key(), $urandom());
    end else if (roll < 97) begin
      send_req(REQ_LIST, $urandom(), $urandom());
    end else begin
      send_req(REQ_UNUSED, $urandom(), $urandom());
    end
  endtask

  task automatic test_empty_list();
    send_req(REQ_LIST, 0, 0);
    send_req(REQ_DEL_KEY, 5, 0);
    send_req(REQ_DEL_HEAD, 0, 0);
    send_req(REQ_DEL_TAIL, 0, 0);
    send_req(REQ_INS_KEY, 9, 9);
    send_req(REQ_UNUSED, KEY_MAX, KEY_MIN);
  endtask

  task automatic test_edge_keys();
    send_req(REQ_INS_HEAD, KEY_MIN, 0);
    send_req(REQ_INS_TAIL, KEY_MAX, 0);
    send_req(REQ_INS_HEAD, 0, KEY_MAX);
    send_req(REQ_INS_KEY, -1, KEY_MAX);
    send_req(REQ_INS_KEY, KEY_MIN, KEY_MIN);
    send_req(REQ_INS_KEY, 5, 12345);
    send_req(REQ_LIST, KEY_MIN, KEY_MAX);
    send_req(REQ_DEL_KEY, KEY_MIN, 0);
    send_req(REQ_DEL_KEY, 77, 0);
    send_req(REQ_DEL_HEAD, 0, 0);
    send_req(REQ_DEL_TAIL, 0, 0);
    send_req(REQ_LIST, 0, 0);
  endtask

  // grow to capacity, shrink to empty, or churn, then overrun the limit a little
  task automatic test_random_traffic();
    traffic_t mode;
    int extra;
    while (items_sent < TOTAL_ITEMS) begin
      mode = traffic_t'($urandom_range(0, 2));
      extra = (mode == CHURN) ? $urandom_range(10, 30) : $urandom_range(2, 5);
      while (items_sent < TOTAL_ITEMS && extra > 0) begin
        send_random(mode);
        if (mode == CHURN || model_keys.size() == ((mode == GROW) ? CAPACITY : 0)) begin
          extra--;
        end
      end
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, item_key", res.item_key, 0);
      end else begin
        if (res.status !== pending_results[0].status)
          report_mismatch("status", 32'(res.status), 32'(pending_results[0].status));
        if (res.item_valid !== pending_results[0].item_valid)
          report_mismatch("item_valid", 32'(res.item_valid),
                          32'(pending_results[0].item_valid));
        if (res.item_key !== pending_results[0].item_key)
          report_mismatch("item_key", res.item_key, pending_results[0].item_key);
        if (res.last !== pending_results[0].last)
          report_mismatch("last", 32'(res.last), 32'(pending_results[0].last));
        if (res.element_count !== pending_results[0].element_count)
          report_mismatch("element_count", 32'(res.element_count),
                          32'(pending_results[0].element_count));
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    wait_idle();
    test_edge_keys();
    wait_idle();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
